>>> src/rcia_pkg.sv
// shared constants, codes and types for the recycling id allocator
// no dependencies
package rcia_pkg;

    localparam int MAX_IDS = 1024;
    localparam int ID_W    = 11;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int PTR_W   = $clog2(MAX_IDS);
    localparam int CNT_W   = $clog2(MAX_IDS + 1);
    localparam int MARK_DEPTH = MAX_IDS + 1;
    localparam int MARK_AW = $clog2(MARK_DEPTH);

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK            = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NOT_ALLOCATED = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL          = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } rcia_cmd_t;

endpackage

>>> src/rcia_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module rcia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/rcia_ctrl.sv
// control state machine: input handshake, execute step, output word valid
// depends on rcia_pkg
module rcia_ctrl
    import rcia_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output rcia_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.capture    = 1'b0;
        cmd.execute    = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/rcia_datapath.sv
// datapath: free id fifo, allocated marks, fresh counter, result registers
// depends on rcia_pkg and rcia_ram
module rcia_datapath
    import rcia_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rcia_cmd_t         cmd,
    input  logic [CMD_W-1:0]  command,
    input  logic [ID_W-1:0]   release_id,
    output logic [ID_W-1:0]   granted_id,
    output logic [STAT_W-1:0] status
);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ID_W-1:0]  fresh_reg, fresh_next;

    logic [CMD_W-1:0]  cmd_reg;
    logic [ID_W-1:0]   rid_reg;
    logic [ID_W-1:0]   granted_reg, granted_next;
    logic [STAT_W-1:0] status_reg, status_next;

    logic              fifo_we;
    logic [ID_W-1:0]   fifo_rdata;
    logic              mark_we;
    logic [MARK_AW-1:0] mark_waddr;
    logic              mark_wdata;
    logic              mark_rdata;
    logic              release_ok;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_IDS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_IDS);
    localparam logic [ID_W-1:0]  ID_MAX   = ID_W'(MAX_IDS);
    localparam logic [ID_W-1:0]  ID_FIRST = ID_W'(1);

    rcia_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_IDS)
    ) u_fifo_ram (
        .clk     (clk),
        .wr_en   (fifo_we),
        .wr_addr (tail_reg),
        .wr_data (rid_reg),
        .rd_en   (cmd.capture),
        .rd_addr (head_reg),
        .rd_data (fifo_rdata)
    );

    rcia_ram #(
        .WIDTH (1),
        .DEPTH (MARK_DEPTH)
    ) u_mark_ram (
        .clk     (clk),
        .wr_en   (mark_we),
        .wr_addr (mark_waddr),
        .wr_data (mark_wdata),
        .rd_en   (cmd.capture),
        .rd_addr (release_id[MARK_AW-1:0]),
        .rd_data (mark_rdata)
    );

    // marks of ids at or above the fresh counter were never set since clear
    assign release_ok = (rid_reg != '0) && (rid_reg <= ID_MAX) && (rid_reg < fresh_reg)
                        && mark_rdata && (count_reg < CNT_MAX);

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        fresh_next   = fresh_reg;
        granted_next = granted_reg;
        status_next  = status_reg;
        fifo_we      = 1'b0;
        mark_we      = 1'b0;
        mark_waddr   = rid_reg[MARK_AW-1:0];
        mark_wdata   = 1'b0;
        if (cmd.execute)
        begin
            granted_next = '0;
            status_next  = STATUS_OK;
            case (cmd_reg)
                CMD_ALLOC:
                begin
                    if (count_reg != '0)
                    begin
                        granted_next = fifo_rdata;
                        head_next    = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                        count_next   = count_reg - 1'b1;
                        mark_we      = (fifo_rdata != '0) && (fifo_rdata <= ID_MAX);
                        mark_waddr   = fifo_rdata[MARK_AW-1:0];
                        mark_wdata   = 1'b1;
                    end
                    else if (fresh_reg <= ID_MAX)
                    begin
                        granted_next = fresh_reg;
                        fresh_next   = fresh_reg + 1'b1;
                        mark_we      = 1'b1;
                        mark_waddr   = fresh_reg[MARK_AW-1:0];
                        mark_wdata   = 1'b1;
                    end
                    else
                    begin
                        status_next = STATUS_FULL;
                    end
                end
                CMD_RELEASE:
                begin
                    if (release_ok)
                    begin
                        mark_we    = 1'b1;
                        mark_wdata = 1'b0;
                        fifo_we    = 1'b1;
                        tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        status_next = STATUS_NOT_ALLOCATED;
                    end
                end
                CMD_CLEAR:
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                    fresh_next = ID_FIRST;
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            fresh_reg <= ID_FIRST;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= command;
            rid_reg <= release_id;
        end
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    assign granted_id = granted_reg;
    assign status     = status_reg;

endmodule

>>> src/recycling_id_allocator_unit.sv
// recycling id allocator: ids 1..MAX_IDS, oldest released id reused first
// capture takes a word and does the registered read of the fifo and mark rams;
//   execute waits for a free output slot, registers the result, reopens the input
// a new word is taken while the previous result still waits on the output
// reset (async, active low) empties the fifo and sets the fresh counter to 1;
//   marks need no clearing pass, ids at or above the fresh counter read as free
module recycling_id_allocator_unit
    import rcia_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  command,
    input  logic [ID_W-1:0]   release_id,
    // result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ID_W-1:0]   granted_id,
    output logic [STAT_W-1:0] status
);

    // capture: request word taken, rams read at fifo head and release id
    // execute: result computed from ram data, state and marks updated
    rcia_cmd_t cmd;

    rcia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // fifo pointers, fresh counter and result word registers
    rcia_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .command    (command),
        .release_id (release_id),
        .granted_id (granted_id),
        .status     (status)
    );

endmodule
